// ===== rtl/serial_frame_parser_xor_unit_defines.svh =====
// Assertion macros shared by the frame parser checker.
`ifndef SERIAL_FRAME_PARSER_XOR_UNIT_DEFINES_SVH
`define SERIAL_FRAME_PARSER_XOR_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define SFPX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SFPX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define SFPX_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sfpx_pkg.sv =====
// Types and constants of the serial frame parser.
`timescale 1ns / 1ps

package sfpx_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic [BYTE_W-1:0] CH_START = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HDR   = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_REPLY = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_ERROR = 8'h21;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DIR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERR_ID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CHK  = 3'd4;

    localparam logic RT_PAYLOAD = 1'b0;
    localparam logic RT_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_HDR  = 4'd1,
        PH_DIR  = 4'd2,
        PH_LEN  = 4'd3,
        PH_ID   = 4'd4,
        PH_DATA = 4'd5,
        PH_CHK  = 4'd6,
        PH_ELEN = 4'd7,
        PH_EID  = 4'd8
    } t_phase;

    typedef struct packed {
        logic                result_type;
        logic [BYTE_W-1:0]   frame_id;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   byte_index;
        logic [BYTE_W-1:0]   payload_length;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   received_checksum;
        logic [BYTE_W-1:0]   expected_checksum;
        logic                last;
    } t_result;

endpackage

// ===== rtl/sfpx_in_stage.sv =====
// Input register of the frame parser.
`timescale 1ns / 1ps

module sfpx_in_stage
    import sfpx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== rtl/sfpx_parse.sv =====
// Frame parser state and per-byte decode.
`timescale 1ns / 1ps

module sfpx_parse
    import sfpx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_ident, n_ident;
    logic [BYTE_W-1:0] r_check, n_check;
    logic [BYTE_W-1:0] r_index, n_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_left  <= '0;
            r_ident <= '0;
            r_check <= '0;
            r_index <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_left  <= n_left;
            r_ident <= n_ident;
            r_check <= n_check;
            r_index <= n_index;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_left      = r_left;
        n_ident     = r_ident;
        n_check     = r_check;
        n_index     = r_index;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.result_type = RT_STATUS;
        o_res.last        = 1'b1;
        case (r_phase)
            PH_HDR: begin
                if (i_byte == CH_HDR) begin
                    n_phase = PH_DIR;
                end else begin
                    n_phase      = PH_HUNT;
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BAD_HDR;
                end
            end
            PH_DIR: begin
                if (i_byte == CH_REPLY) begin
                    n_phase = PH_LEN;
                end else if (i_byte == CH_ERROR) begin
                    n_phase = PH_ELEN;
                end else begin
                    n_phase      = PH_HUNT;
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BAD_DIR;
                end
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_check = i_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_ident = i_byte;
                n_check = r_check ^ i_byte;
                n_index = '0;
                n_left  = r_len;
                n_phase = (r_len == '0) ? PH_CHK : PH_DATA;
            end
            PH_DATA: begin
                o_res_valid          = 1'b1;
                o_res.result_type    = RT_PAYLOAD;
                o_res.last           = 1'b0;
                o_res.frame_id       = r_ident;
                o_res.payload_byte   = i_byte;
                o_res.byte_index     = r_index;
                o_res.payload_length = r_len;
                o_res.status         = ST_OK;
                n_check = r_check ^ i_byte;
                n_index = r_index + 1'b1;
                n_left  = r_left - 1'b1;
                if (n_left == '0) begin
                    n_phase = PH_CHK;
                end
            end
            PH_CHK: begin
                n_phase                 = PH_HUNT;
                o_res_valid             = 1'b1;
                o_res.frame_id          = r_ident;
                o_res.payload_length    = r_len;
                o_res.status            = (i_byte == r_check) ? ST_OK : ST_BAD_CHK;
                o_res.received_checksum = i_byte;
                o_res.expected_checksum = r_check;
            end
            PH_ELEN: begin
                n_len   = i_byte;
                n_phase = PH_EID;
            end
            PH_EID: begin
                n_ident              = i_byte;
                n_phase              = PH_HUNT;
                o_res_valid          = 1'b1;
                o_res.frame_id       = i_byte;
                o_res.payload_length = r_len;
                o_res.status         = ST_ERR_ID;
            end
            default: begin
                n_phase = (i_byte == CH_START) ? PH_HDR : PH_HUNT;
            end
        endcase
    end

endmodule

// ===== rtl/sfpx_out_stage.sv =====
// Result register of the frame parser.
`timescale 1ns / 1ps

module sfpx_out_stage
    import sfpx_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    input  t_result                i_res,
    output logic                   o_ready,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tuser,
    output logic                   o_tlast
);

    logic    r_valid;
    t_result r_res;

    assign o_ready  = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tuser  = r_res.result_type;
    assign o_tlast  = r_res.last;
    assign o_tdata  = {5'd0,
                       r_res.expected_checksum,
                       r_res.received_checksum,
                       r_res.status,
                       r_res.payload_length,
                       r_res.byte_index,
                       r_res.payload_byte,
                       r_res.frame_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/serial_frame_parser_xor_unit.sv =====
// Top level of the serial frame parser with XOR checksum.
// Usage:
//   Slave stream: one received serial byte per request on i_s_axis_tdata.
//   Master stream: zero or one result per byte; tuser is the result type
//   (payload byte or status), tlast marks every status result.
//   The parser hunts for '$', 'M' and a direction byte; for a reply it
//   emits each payload byte with its id and index and closes the frame with a status
//   that carries the received and locally computed XOR checksum.
//   A byte accepted into the input register is decoded combinationally and its
//   result, if any, is captured in the result register once that register can
//   take it.
//   Throughput: one byte per cycle while the receiver holds tready high; the
//   per-byte decode is a single combinational step between the input register and the result register.
//   Reset (i_rst_n low at a clock edge) empties both registers and returns
//   the parser to hunting. When the receiver holds tready low the result
//   register holds, the input register fills, and o_s_axis_tready drops
//   until the result is taken.
`timescale 1ns / 1ps

module serial_frame_parser_xor_unit
    import sfpx_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] rx_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] frame id, [15:8] payload_byte, [23:16] byte_index,
    // [31:24] payload_length, [34:32] status, [42:35] received_checksum,
    // [50:43] expected_checksum, [55:51] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,   // [0] result_type
    output logic                   o_m_axis_tlast    // last
);

    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_out_ready;
    logic              w_step;
    logic              w_res_valid;
    t_result           w_res;

    assign w_step = w_in_valid && w_out_ready;

    sfpx_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_take  (w_out_ready),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    sfpx_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sfpx_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_step && w_res_valid),
        .i_res       (w_res),
        .o_ready     (w_out_ready),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule

// ===== rtl/sfpx_checker.sv =====
// Port-level assertions for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "serial_frame_parser_xor_unit_defines.svh"

module sfpx_checker
    import sfpx_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                   o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    logic                   w_stall;
    logic [OUT_TDATA_W+2:0] w_out_word;
    logic                   w_payload;
    logic                   w_payload_ok;
    logic                   w_out_empty;

    assign w_stall      = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_word   = {o_m_axis_tvalid, o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};
    assign w_payload    = o_m_axis_tvalid && (o_m_axis_tuser == RT_PAYLOAD);
    assign w_payload_ok = !o_m_axis_tlast && (o_m_axis_tdata[50:32] == '0);
    assign w_out_empty  = !o_m_axis_tvalid;

    // reset empties the result register
    `SFPX_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    // a stalled result holds its payload
    `SFPX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, $stable(w_out_word), "stalled result moved")

    // payload results never close a frame and carry no status or checksums
    `SFPX_ASSERT_NOW(a_pay_shape, i_clk, i_rst_n, w_payload, w_payload_ok, "payload malformed")

    // input never stalls while the result register is empty
    `SFPX_ASSERT_NOW(a_idle_open, i_clk, i_rst_n, w_out_empty, o_s_axis_tready, "stall on empty")

endmodule

bind serial_frame_parser_xor_unit sfpx_checker u_sfpx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/sv/tb_serial_frame_parser_xor_unit.sv =====
// Self-checking stream testbench for the serial frame parser with XOR checksum.
`timescale 1ns / 1ps

module tb_serial_frame_parser_xor_unit;
    import sfpx_pkg::*;

    localparam int ITEMS      = 1350;
    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 200;
    localparam int N_DIRECTED = 25;

    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                typed;
        t_result           want;
    } t_row;

    logic                   i_clk;
    logic                   rst_n   = 1'b0;
    logic                   s_valid = 1'b0;
    logic [BYTE_W-1:0]      s_data  = '0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    // parser state mirror
    t_phase            rx_phase  = PH_HUNT;
    logic [BYTE_W-1:0] rx_len    = '0;
    logic [BYTE_W-1:0] rx_left   = '0;
    logic [BYTE_W-1:0] rx_id     = '0;
    logic [BYTE_W-1:0] rx_xor    = '0;
    logic [BYTE_W-1:0] rx_index  = '0;

    t_result pending_results[$];
    t_row    directed_rows[N_DIRECTED];
    int      n_err      = 0;
    int      n_items    = 0;
    int      idle_count = 0;
    bit      s_burst    = 1'b0;
    bit      m_burst    = 1'b0;
    bit      hold_req   = 1'b0;

    serial_frame_parser_xor_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [7:0] rx_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // id, byte, index, length, status, rx/exp checksum
        .o_m_axis_tuser  (o_m_axis_tuser),  // [0] result_type
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result status_res(input logic [BYTE_W-1:0] id,
                                           input logic [BYTE_W-1:0] len,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [BYTE_W-1:0] rc,
                                           input logic [BYTE_W-1:0] ec);
        t_result r;
        r = '0;
        r.result_type       = RT_STATUS;
        r.frame_id          = id;
        r.payload_length    = len;
        r.status            = st;
        r.received_checksum = rc;
        r.expected_checksum = ec;
        r.last              = 1'b1;
        return r;
    endfunction

    // advances the parser mirror by one byte; returns 1 when a result is due
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_result r);
        r = '0;
        case (rx_phase)
            PH_HDR: begin
                if (b == CH_HDR) begin
                    rx_phase = PH_DIR;
                    return 1'b0;
                end
                rx_phase = PH_HUNT;
                r = status_res('0, '0, ST_BAD_HDR, '0, '0);
                return 1'b1;
            end
            PH_DIR: begin
                if (b == CH_REPLY) begin
                    rx_phase = PH_LEN;
                    return 1'b0;
                end
                if (b == CH_ERROR) begin
                    rx_phase = PH_ELEN;
                    return 1'b0;
                end
                rx_phase = PH_HUNT;
                r = status_res('0, '0, ST_BAD_DIR, '0, '0);
                return 1'b1;
            end
            PH_LEN: begin
                rx_len   = b;
                rx_xor   = b;
                rx_phase = PH_ID;
                return 1'b0;
            end
            PH_ID: begin
                rx_id    = b;
                rx_xor   = rx_xor ^ b;
                rx_index = '0;
                rx_left  = rx_len;
                rx_phase = (rx_len == '0) ? PH_CHK : PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                r.result_type    = RT_PAYLOAD;
                r.frame_id       = rx_id;
                r.payload_byte   = b;
                r.byte_index     = rx_index;
                r.payload_length = rx_len;
                rx_xor   = rx_xor ^ b;
                rx_index = rx_index + 8'd1;
                rx_left  = rx_left - 8'd1;
                if (rx_left == '0) rx_phase = PH_CHK;
                return 1'b1;
            end
            PH_CHK: begin
                rx_phase = PH_HUNT;
                r = status_res(rx_id, rx_len, (b == rx_xor) ? ST_OK : ST_BAD_CHK, b, rx_xor);
                return 1'b1;
            end
            PH_ELEN: begin
                rx_len   = b;
                rx_phase = PH_EID;
                return 1'b0;
            end
            PH_EID: begin
                rx_id    = b;
                rx_phase = PH_HUNT;
                r = status_res(b, rx_len, ST_ERR_ID, '0, '0);
                return 1'b1;
            end
            default: begin
                rx_phase = (b == CH_START) ? PH_HDR : PH_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (n_err < 40) $display("MISMATCH at %0t ns: %s", $time, what);
        n_err++;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    // one request on the input side; a typed row overrides the mirror's result
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit ignored = 1'b0,
                             input bit typed = 1'b0, input t_result want = '0);
        t_result r;
        bit      due;
        int      gap;
        gap = s_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        due = parse_byte(b, r);
        if (typed) pending_results = {pending_results, want};
        else if (due) pending_results = {pending_results, r};
        if (!ignored) n_items++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] len, input bit hold);
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        id  = BYTE_W'($urandom);
        sum = len ^ id;
        send_byte(CH_START);
        send_byte(CH_HDR);
        send_byte(CH_REPLY);
        send_byte(len);
        send_byte(id);
        if (hold) hold_req = 1'b1;
        for (int k = 0; k < len; k++) begin
            b   = BYTE_W'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if ($urandom_range(0, 99) < 15) sum = BYTE_W'($urandom);
        send_byte(sum);
    endtask

    // receiver: random stalls, one long hold on request
    initial begin : result_sink
        int stall;
        int n_taken;
        n_taken = 0;
        wait (rst_n);
        forever begin
            stall = m_burst ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            n_taken++;
            if ((n_taken % 32) == 0) m_burst = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_ready && o_m_axis_tvalid) begin
            got.result_type       = o_m_axis_tuser;
            got.frame_id          = o_m_axis_tdata[7:0];
            got.payload_byte      = o_m_axis_tdata[15:8];
            got.byte_index        = o_m_axis_tdata[23:16];
            got.payload_length    = o_m_axis_tdata[31:24];
            got.status            = o_m_axis_tdata[34:32];
            got.received_checksum = o_m_axis_tdata[42:35];
            got.expected_checksum = o_m_axis_tdata[50:43];
            got.last              = o_m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("result_type", BYTE_W'(got.result_type),
                            BYTE_W'(want.result_type));
                check_field("frame_id", got.frame_id, want.frame_id);
                check_field("payload_byte", got.payload_byte, want.payload_byte);
                check_field("byte_index", got.byte_index, want.byte_index);
                check_field("payload_length", got.payload_length, want.payload_length);
                check_field("status", BYTE_W'(got.status), BYTE_W'(want.status));
                check_field("received_checksum", got.received_checksum,
                            want.received_checksum);
                check_field("expected_checksum", got.expected_checksum,
                            want.expected_checksum);
                check_field("last", BYTE_W'(got.last), BYTE_W'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (m_ready && o_m_axis_tvalid)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int               kind;
        int               frame_no;
        int               n_noise;
        logic [BYTE_W-1:0] b;

        // hunting noise, bad header, bad direction, error reply, empty and bad-sum frames
        directed_rows[0]  = '{8'h00, 1'b0, '0};
        directed_rows[1]  = '{8'hFF, 1'b0, '0};
        directed_rows[2]  = '{CH_START, 1'b0, '0};
        directed_rows[3]  = '{8'h00, 1'b1, status_res('0, '0, ST_BAD_HDR, '0, '0)};
        directed_rows[4]  = '{CH_START, 1'b0, '0};
        directed_rows[5]  = '{CH_HDR, 1'b0, '0};
        directed_rows[6]  = '{8'hFF, 1'b1, status_res('0, '0, ST_BAD_DIR, '0, '0)};
        directed_rows[7]  = '{CH_START, 1'b0, '0};
        directed_rows[8]  = '{CH_HDR, 1'b0, '0};
        directed_rows[9]  = '{CH_ERROR, 1'b0, '0};
        directed_rows[10] = '{8'hFF, 1'b0, '0};
        directed_rows[11] = '{8'h00, 1'b1, status_res(8'h00, 8'hFF, ST_ERR_ID, '0, '0)};
        directed_rows[12] = '{CH_START, 1'b0, '0};
        directed_rows[13] = '{CH_HDR, 1'b0, '0};
        directed_rows[14] = '{CH_REPLY, 1'b0, '0};
        directed_rows[15] = '{8'h00, 1'b0, '0};
        directed_rows[16] = '{8'hAB, 1'b0, '0};
        directed_rows[17] = '{8'hAB, 1'b1, status_res(8'hAB, 8'h00, ST_OK, 8'hAB, 8'hAB)};
        directed_rows[18] = '{CH_START, 1'b0, '0};
        directed_rows[19] = '{CH_HDR, 1'b0, '0};
        directed_rows[20] = '{CH_REPLY, 1'b0, '0};
        directed_rows[21] = '{8'h01, 1'b0, '0};
        directed_rows[22] = '{8'hFF, 1'b0, '0};
        directed_rows[23] = '{8'h00, 1'b0, '0};
        directed_rows[24] = '{8'h00, 1'b0, '0};

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_byte(directed_rows[k].rx_byte, 1'b0, directed_rows[k].typed,
                      directed_rows[k].want);

        frame_no = 0;
        while (n_items < ITEMS) begin
            kind = $urandom_range(0, 99);
            if (frame_no == 15 || frame_no == 50) begin
                send_frame(8'hFF, frame_no == 50);
            end else if (kind < 65) begin
                send_frame(BYTE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                               : $urandom_range(0, 12)),
                           1'b0);
            end else if (kind < 75) begin
                send_byte(CH_START);
                send_byte(CH_HDR);
                send_byte(CH_ERROR);
                send_byte(BYTE_W'($urandom));
                send_byte(BYTE_W'($urandom));
            end else if (kind < 82) begin
                do b = BYTE_W'($urandom); while (b == CH_HDR);
                send_byte(CH_START);
                send_byte(b);
            end else if (kind < 89) begin
                do b = BYTE_W'($urandom); while (b == CH_REPLY || b == CH_ERROR);
                send_byte(CH_START);
                send_byte(CH_HDR);
                send_byte(b);
            end else begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) begin
                    do b = BYTE_W'($urandom); while (b == CH_START);
                    send_byte(b, 1'b1);
                end
            end
            frame_no++;
            if ((frame_no % 16) == 0) s_burst = ($urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_err == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sfpx_pkg.sv
rtl/sfpx_in_stage.sv
rtl/sfpx_parse.sv
rtl/sfpx_out_stage.sv
rtl/serial_frame_parser_xor_unit.sv
rtl/sfpx_checker.sv
tb/sv/tb_serial_frame_parser_xor_unit.sv
